// ----- rtl/pda_pkg.sv -----
package pda_pkg;

    // Width of the time step field, unsigned fixed point seconds.
    localparam int STEP_W = 20;

    // Bits of the multiplier consumed per step of the shared multiplier.
    localparam int MUL_DIGIT = 8;

    // Configuration register index.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_OUT_MIN        = 3'd3,
        REG_OUT_MAX        = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_DEAD_BAND      = 3'd6
    } cfg_reg_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic start;
        logic shift_dt;
    } mul_ctl_t;

endpackage

// ----- rtl/pda_sample_if.sv -----
interface pda_sample_if #(
    parameter int DATA_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   error_in;
    logic [pda_pkg::STEP_W-1:0]     time_step;
    logic                           clear_state;

    modport source (output valid, output error_in, output time_step, output clear_state,
                    input ready);
    modport sink   (input valid, input error_in, input time_step, input clear_state,
                    output ready);
endinterface

// ----- rtl/pda_drive_if.sv -----
interface pda_drive_if #(
    parameter int DATA_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   drive_out;
    logic                           skipped;

    modport source (output valid, output drive_out, output skipped, input ready);
    modport sink   (input valid, input drive_out, input skipped, output ready);
endinterface

// ----- rtl/pda_cfg_if.sv -----
interface pda_cfg_if #(
    parameter int DATA_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic [pda_pkg::CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pda_mul.sv -----
module pda_mul #(
    parameter int DATA_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int DT_FRAC_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pda_pkg::mul_ctl_t    ctl,
    input  logic signed [((DATA_WIDTH+1 > pda_pkg::STEP_W+1) ? DATA_WIDTH+1
                          : pda_pkg::STEP_W+1)-1:0] a,
    input  logic signed [((DATA_WIDTH+1 > pda_pkg::STEP_W+1) ? DATA_WIDTH+1
                          : pda_pkg::STEP_W+1)-1:0] b,
    output logic                 done,
    output logic signed [DATA_WIDTH-1:0] result
);
    import pda_pkg::*;

    localparam int OPW   = (DATA_WIDTH+1 > STEP_W+1) ? DATA_WIDTH+1 : STEP_W+1;
    localparam int NSTEP = (OPW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW    = NSTEP * MUL_DIGIT;
    localparam int AW    = OPW + BW;
    localparam int CW    = $clog2(NSTEP + 1);

    logic [OPW-1:0]          mcand_reg;
    logic [AW-1:0]           acc_reg;
    logic                    neg_reg;
    logic                    shdt_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    run_reg;
    logic                    post_reg;
    logic                    done_reg;
    logic signed [DATA_WIDTH-1:0] result_reg;

    logic [OPW-1:0]          mag_a;
    logic [OPW-1:0]          mag_b;
    logic [OPW+MUL_DIGIT-1:0] pp;
    logic [OPW+MUL_DIGIT-1:0] psum;
    logic [AW-1:0]           acc_next;
    logic signed [AW:0]      prod_s;
    logic signed [AW:0]      prod_sh;
    logic signed [DATA_WIDTH-1:0] sat_val;

    assign mag_a = a[OPW-1] ? OPW'(-a) : OPW'(a);
    assign mag_b = b[OPW-1] ? OPW'(-b) : OPW'(b);

    // One digit of the multiplier per step; shift the accumulator right.
    assign pp       = (OPW+MUL_DIGIT)'(mcand_reg) *
                      (OPW+MUL_DIGIT)'(acc_reg[MUL_DIGIT-1:0]);
    assign psum     = pp + (OPW+MUL_DIGIT)'(acc_reg[AW-1:BW]);
    assign acc_next = {psum, acc_reg[BW-1:MUL_DIGIT]};

    always_comb
    begin
        prod_s  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        prod_sh = shdt_reg ? (prod_s >>> DT_FRAC_BITS) : (prod_s >>> FRAC_BITS);
        if ((&prod_sh[AW:DATA_WIDTH-1]) || !(|prod_sh[AW:DATA_WIDTH-1]))
        begin
            sat_val = prod_sh[DATA_WIDTH-1:0];
        end
        else if (prod_sh[AW])
        begin
            sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            post_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            post_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NSTEP);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                post_reg <= 1'b1;
            end
        end
        else if (post_reg)
        begin
            post_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mcand_reg <= mag_a;
            acc_reg   <= {{OPW{1'b0}}, BW'(mag_b)};
            neg_reg   <= a[OPW-1] ^ b[OPW-1];
            shdt_reg  <= ctl.shift_dt;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
        end
        if (post_reg)
        begin
            result_reg <= sat_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/pda_div.sv -----
module pda_div #(
    parameter int DATA_WIDTH   = 32,
    parameter int DT_FRAC_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] num,
    input  logic [pda_pkg::STEP_W-1:0]   step,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quot
);
    import pda_pkg::*;

    localparam int DVW = DATA_WIDTH + DT_FRAC_BITS;
    localparam int CW  = $clog2(DVW + 1);

    logic [DVW-1:0]          dq_reg;
    logic [STEP_W-1:0]       rem_reg;
    logic [STEP_W-1:0]       dvs_reg;
    logic                    neg_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    run_reg;
    logic                    post_reg;
    logic                    done_reg;
    logic signed [DATA_WIDTH-1:0] quot_reg;

    logic [DATA_WIDTH-1:0]   mag_num;
    logic [STEP_W:0]         trial;
    logic                    q_bit;
    logic [STEP_W:0]         trial_sub;
    logic [DATA_WIDTH-1:0]   cap;
    logic [DATA_WIDTH-1:0]   q_cap;
    logic [DATA_WIDTH-1:0]   q_fin;

    assign mag_num   = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);

    // Restoring step: bring in the next dividend bit, subtract when it fits.
    assign trial     = {rem_reg, dq_reg[DVW-1]};
    assign q_bit     = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    // Clamp magnitude: one more on the negative side.
    assign cap   = {neg_reg, {(DATA_WIDTH-1){~neg_reg}}};
    assign q_cap = (dq_reg > DVW'(cap)) ? cap : dq_reg[DATA_WIDTH-1:0];
    assign q_fin = neg_reg ? -q_cap : q_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            post_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            post_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DVW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                post_reg <= 1'b1;
            end
        end
        else if (post_reg)
        begin
            post_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {mag_num, {DT_FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= step;
            neg_reg <= num[DATA_WIDTH-1];
        end
        else if (run_reg)
        begin
            rem_reg <= q_bit ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
            dq_reg  <= {dq_reg[DVW-2:0], q_bit};
        end
        if (post_reg)
        begin
            quot_reg <= q_fin;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/pid_deadzone_antiwindup.sv -----
// PID controller with dead band, integral anti-windup and output clamp.
// A computing request passes from accept to drive.valid through four runs of the 8-bit-digit
// multiplier, the bit-serial divider and the three sequencer steps S_INTEG, S_SUM and S_FIN;
// clear or zero-step requests go straight from S_IDLE to S_FIN.
// One request at a time: a new one is taken only in S_IDLE; a stalled drive channel holds it off.
// Reset: rst_n is asynchronous active low; it zeroes the state and loads register defaults.
module pid_deadzone_antiwindup #(
    parameter int DATA_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int DT_FRAC_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    pda_sample_if.sink  sample,
    pda_drive_if.source drive,
    pda_cfg_if.sink     cfg
);
    import pda_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int OPW = (DATA_WIDTH+1 > STEP_W+1) ? DATA_WIDTH+1 : STEP_W+1;

    // Sequencer: each multiply state launches the shared multiplier once and
    // waits for its done pulse.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL_P  = 9'b000000010,
        S_MUL_IE = 9'b000000100,
        S_INTEG  = 9'b000001000,
        S_MUL_I  = 9'b000010000,
        S_MUL_N  = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;

    // Configuration registers.
    logic signed [DW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DW-1:0] out_min_reg, out_max_reg, limit_reg, band_reg;

    // Controller state.
    logic signed [DW-1:0] integral_reg;
    logic signed [DW-1:0] prev_reg;

    // Per-request working values.
    logic signed [DW-1:0] e_reg;
    logic [STEP_W-1:0]    dt_reg;
    logic signed [DW-1:0] p_reg, ie_reg, i_reg, d_reg;

    // Pending result and output register.
    logic signed [DW-1:0] res_val_reg;
    logic                 res_skip_reg;
    logic signed [DW-1:0] out_val_reg;
    logic                 out_skip_reg;
    logic                 out_valid_reg;

    logic                 accept;
    logic                 out_free;

    // Shared multiplier, and the divider.
    mul_ctl_t                mul_ctl;
    logic signed [OPW-1:0]   mul_a, mul_b;
    logic                    mul_done;
    logic signed [DW-1:0]    mul_res;
    logic                    div_start;
    logic                    div_done;
    logic signed [DW-1:0]    div_q;

    // Dead band.
    logic signed [DW:0]   e_ext, band_ext;
    logic signed [DW-1:0] e_banded;

    // Integral update.
    logic signed [DW:0]   isum;
    logic signed [DW-1:0] isat;
    logic signed [DW:0]   lim_neg;
    logic signed [DW-1:0] integ_new;

    // Output sum and clamp.
    logic signed [DW+1:0] osum;
    logic signed [DW-1:0] oclamp;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || drive.ready;

    assign sample.ready    = (state_reg == S_IDLE);
    assign drive.valid     = out_valid_reg;
    assign drive.drive_out = out_val_reg;
    assign drive.skipped   = out_skip_reg;
    assign cfg.ready       = 1'b1;

    // Zero errors strictly inside plus or minus the band.
    always_comb
    begin
        e_ext    = (DW+1)'(sample.error_in);
        band_ext = (DW+1)'(band_reg);
        if ((e_ext > -band_ext) && (e_ext < band_ext))
        begin
            e_banded = '0;
        end
        else
        begin
            e_banded = sample.error_in;
        end
    end

    // Saturating integral add, then the magnitude clamp when the limit is positive.
    always_comb
    begin
        isum    = (DW+1)'(integral_reg) + (DW+1)'(ie_reg);
        lim_neg = -((DW+1)'(limit_reg));
        if ((isum[DW] == isum[DW-1]))
        begin
            isat = isum[DW-1:0];
        end
        else if (isum[DW])
        begin
            isat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            isat = {1'b0, {(DW-1){1'b1}}};
        end
        integ_new = isat;
        if (limit_reg > 0)
        begin
            if (isat > limit_reg)
            begin
                integ_new = limit_reg;
            end
            else if ((DW+1)'(isat) < lim_neg)
            begin
                integ_new = lim_neg[DW-1:0];
            end
        end
    end

    // Sum the three terms; test the upper bound first. Inside both bounds
    // the sum is already in range.
    always_comb
    begin
        osum = (DW+2)'(p_reg) + (DW+2)'(i_reg) + (DW+2)'(d_reg);
        if (osum > (DW+2)'(out_max_reg))
        begin
            oclamp = out_max_reg;
        end
        else if (osum < (DW+2)'(out_min_reg))
        begin
            oclamp = out_min_reg;
        end
        else
        begin
            oclamp = osum[DW-1:0];
        end
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = OPW'(gain_p_reg);
        mul_b = OPW'(e_reg);
        mul_ctl.shift_dt = 1'b0;
        unique case (state_reg)
            S_MUL_IE:
            begin
                mul_a = OPW'(e_reg);
                mul_b = OPW'($signed({1'b0, dt_reg}));
                mul_ctl.shift_dt = 1'b1;
            end
            S_MUL_I:
            begin
                mul_a = OPW'(gain_i_reg);
                mul_b = OPW'(integral_reg);
            end
            S_MUL_N:
            begin
                mul_a = OPW'(gain_d_reg);
                mul_b = OPW'(e_reg) - OPW'(prev_reg);
            end
            default:
            begin
                mul_a = OPW'(gain_p_reg);
                mul_b = OPW'(e_reg);
            end
        endcase
        mul_ctl.start = launch_reg && ((state_reg == S_MUL_P) || (state_reg == S_MUL_IE) ||
                                       (state_reg == S_MUL_I) || (state_reg == S_MUL_N));
    end

    assign div_start = launch_reg && (state_reg == S_DIV);

    pda_mul #(
        .DATA_WIDTH   (DATA_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .DT_FRAC_BITS (DT_FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    // The gain_d product feeds the divider straight from the multiplier's
    // result register, which holds until the next launch.
    pda_div #(
        .DATA_WIDTH   (DATA_WIDTH),
        .DT_FRAC_BITS (DT_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_res),
        .step  (dt_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.clear_state || (sample.time_step == '0))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next  = S_MUL_P;
                        launch_next = 1'b1;
                    end
                end
            end
            S_MUL_P:
            begin
                if (mul_done)
                begin
                    state_next  = S_MUL_IE;
                    launch_next = 1'b1;
                end
            end
            S_MUL_IE:
            begin
                if (mul_done)
                begin
                    state_next = S_INTEG;
                end
            end
            S_INTEG:
            begin
                state_next  = S_MUL_I;
                launch_next = 1'b1;
            end
            S_MUL_I:
            begin
                if (mul_done)
                begin
                    state_next  = S_MUL_N;
                    launch_next = 1'b1;
                end
            end
            S_MUL_N:
            begin
                if (mul_done)
                begin
                    state_next  = S_DIV;
                    launch_next = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold the result until the output register frees up.
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, controller state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_reg      <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_min_reg   <= {1'b1, {(DW-1){1'b0}}};
            out_max_reg   <= {1'b0, {(DW-1){1'b1}}};
            limit_reg     <= '0;
            band_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_GAIN_P:         gain_p_reg  <= cfg.data;
                    REG_GAIN_I:         gain_i_reg  <= cfg.data;
                    REG_GAIN_D:         gain_d_reg  <= cfg.data;
                    REG_OUT_MIN:        out_min_reg <= cfg.data;
                    REG_OUT_MAX:        out_max_reg <= cfg.data;
                    REG_INTEGRAL_LIMIT: limit_reg   <= cfg.data;
                    REG_DEAD_BAND:      band_reg    <= cfg.data;
                    default:            ;
                endcase
            end

            // A clear request zeroes the state.
            if (accept && sample.clear_state)
            begin
                integral_reg <= '0;
                prev_reg     <= '0;
            end
            if (state_reg == S_INTEG)
            begin
                integral_reg <= integ_new;
            end
            // Advance the previous error once the difference is in the multiplier.
            if ((state_reg == S_MUL_N) && mul_done)
            begin
                prev_reg <= e_reg;
            end

            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (drive.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working values and payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg        <= e_banded;
            dt_reg       <= sample.time_step;
            res_val_reg  <= '0;
            res_skip_reg <= 1'b1;
        end
        if ((state_reg == S_MUL_P) && mul_done)
        begin
            p_reg <= mul_res;
        end
        if ((state_reg == S_MUL_IE) && mul_done)
        begin
            ie_reg <= mul_res;
        end
        if ((state_reg == S_MUL_I) && mul_done)
        begin
            i_reg <= mul_res;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            d_reg <= div_q;
        end
        if (state_reg == S_SUM)
        begin
            res_val_reg  <= oclamp;
            res_skip_reg <= 1'b0;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            out_val_reg  <= res_val_reg;
            out_skip_reg <= res_skip_reg;
        end
    end

endmodule

// ----- tb/pid_deadzone_antiwindup_tb.sv -----
module pid_deadzone_antiwindup_tb;

    import pda_pkg::*;

    localparam int DW        = 32;
    localparam int FRAC      = 16;
    localparam int STEP_FRAC = 20;

    // Allow the longest compute request plus margin to finish.
    localparam int SETTLE_CYCLES = 128;

    localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] Q_ONE = 32'sh0001_0000;
    localparam longint DATA_MAX = 64'sd2147483647;
    localparam longint DATA_MIN = -64'sd2147483648;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // Index with no register behind it; the block must drop such writes.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [DW-1:0] drive;
        logic                 skipped;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pda_sample_if #(.DATA_WIDTH(DW)) sample_ch ();
    pda_drive_if  #(.DATA_WIDTH(DW)) drive_ch ();
    pda_cfg_if    #(.DATA_WIDTH(DW)) cfg_ch ();

    pid_deadzone_antiwindup #(
        .DATA_WIDTH  (DW),
        .FRAC_BITS   (FRAC),
        .DT_FRAC_BITS(STEP_FRAC)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .drive (drive_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Mirror of the register file, loaded with the reset defaults.
    longint k_p       = 0;
    longint k_i       = 0;
    longint k_d       = 0;
    longint lim_lo    = DATA_MIN;
    longint lim_hi    = DATA_MAX;
    longint integ_cap = 0;
    longint band      = 0;

    // Controller state as the block should hold it.
    longint integ_acc = 0;
    longint last_err  = 0;

    drive_result_t expected_drives[$];
    int            faults      = 0;
    bit            steady_flow = 1'b0;

    // Saturate to the signed data range.
    function automatic longint clamp_data(input logic signed [127:0] v);
        if (v > DATA_MAX)
            return DATA_MAX;
        if (v < DATA_MIN)
            return DATA_MIN;
        return longint'(v);
    endfunction

    // Full-width product, arithmetic right shift, then saturate.
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int unsigned sh);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return clamp_data((wa * wb) >>> sh);
    endfunction

    // Derivative rate: num * 2^STEP_FRAC / dt, truncated toward zero, saturated.
    function automatic longint rate_term(input longint num, input longint dt);
        logic signed [127:0] wn;
        logic signed [127:0] wd;
        wn = num;
        wd = dt;
        return clamp_data((wn <<< STEP_FRAC) / wd);
    endfunction

    // Work out the drive value for one request and advance the controller state.
    function automatic void compute_drive(input logic signed [DW-1:0] err,
                                          input logic [STEP_W-1:0] step,
                                          input logic clr,
                                          output drive_result_t res);
        longint e;
        longint dt;
        longint p;
        longint i;
        longint d;
        longint total;
        e           = err;
        dt          = longint'(step);
        res.drive   = '0;
        res.skipped = 1'b1;
        // Clear wins over everything else.
        if (clr) begin
            integ_acc = 0;
            last_err  = 0;
            return;
        end
        // A zero time step leaves the state alone.
        if (dt == 0)
            return;
        if (e > -band && e < band)
            e = 0;
        p = scaled_product(k_p, e, FRAC);
        integ_acc = clamp_data(integ_acc + scaled_product(e, dt, STEP_FRAC));
        // Anti-windup clamp only acts for a positive limit.
        if (integ_cap > 0) begin
            if (integ_acc > integ_cap)
                integ_acc = integ_cap;
            else if (integ_acc < -integ_cap)
                integ_acc = -integ_cap;
        end
        i = scaled_product(k_i, integ_acc, FRAC);
        d = rate_term(scaled_product(k_d, e - last_err, FRAC), dt);
        last_err = e;
        // Upper bound is tested first, so an inverted window still resolves.
        total = p + i + d;
        if (total > lim_hi)
            total = lim_hi;
        else if (total < lim_lo)
            total = lim_lo;
        else
            total = clamp_data(total);
        res.drive   = total[DW-1:0];
        res.skipped = 1'b0;
    endfunction

    // Offer one request; record its expected drive once the block takes it.
    // Valid stays high afterward so back-to-back requests need no gap.
    task automatic send_sample(input logic signed [DW-1:0] err,
                               input logic [STEP_W-1:0] step,
                               input logic clr);
        int            gap;
        drive_result_t res;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.error_in    <= err;
        sample_ch.time_step   <= step;
        sample_ch.clear_state <= clr;
        do @(posedge clk); while (!sample_ch.ready);
        compute_drive(err, step, clr, res);
        expected_drives.push_back(res);
    endtask

    // Drop the request line, wait for every drive value, then let the block go idle.
    task automatic settle_block();
        sample_ch.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid is left high for the next write of the burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_GAIN_P:         k_p       = longint'($signed(val));
            REG_GAIN_I:         k_i       = longint'($signed(val));
            REG_GAIN_D:         k_d       = longint'($signed(val));
            REG_OUT_MIN:        lim_lo    = longint'($signed(val));
            REG_OUT_MAX:        lim_hi    = longint'($signed(val));
            REG_INTEGRAL_LIMIT: integ_cap = longint'($signed(val));
            REG_DEAD_BAND:      band      = longint'($signed(val));
            default:            ;
        endcase
    endtask

    // Load all registers once the block is idle, plus a stray write to an unused index.
    task automatic apply_config(input logic signed [DW-1:0] gp, gi, gd, lo, hi, cap, db);
        settle_block();
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_INTEGRAL_LIMIT, cap);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_UNUSED, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [DW-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return $urandom;
            default: return $signed(32'($urandom_range(0, 32'h6_0000))) - 32'sh3_0000;
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_error();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            default: return $signed(32'($urandom_range(0, 32'h4_0000))) - 32'sh2_0000;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? STEP_MAX : STEP_W'(1);
            2, 3:    return STEP_W'($urandom_range(1, STEP_MAX));
            default: return STEP_W'($urandom_range(1, 32'h4000));
        endcase
    endfunction

    // Zero-state defaults: every drive is zero, clear and zero step report skipped.
    task automatic test_reset_defaults();
        send_sample(Q_MAX, STEP_W'(1), 1'b0);
        send_sample(Q_ONE, '0, 1'b0);
        send_sample(Q_MIN, STEP_MAX, 1'b1);
    endtask

    // Extreme gains and errors: every term saturates somewhere.
    task automatic test_extremes();
        apply_config(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0, '0);
        send_sample(Q_MIN, STEP_MAX, 1'b0);
        send_sample(Q_MAX, STEP_W'(1), 1'b0);
        send_sample(Q_MIN, STEP_W'(1), 1'b0);
        send_sample('0, STEP_MAX, 1'b0);
        send_sample(Q_MAX, STEP_MAX, 1'b1);
    endtask

    // Dead band edges, integral clamp at both signs, then negative dead bands.
    task automatic test_dead_band();
        apply_config(Q_ONE, 32'sh8000, 32'sh4000, Q_MIN, Q_MAX, Q_ONE, 32'sh8000);
        send_sample(32'sh7FFF, STEP_W'(32'h400), 1'b0);
        send_sample(-32'sh7FFF, STEP_W'(32'h400), 1'b0);
        send_sample(32'sh8000, STEP_W'(32'h400), 1'b0);
        send_sample(-32'sh8000, STEP_W'(32'h400), 1'b0);
        send_sample(Q_MAX, STEP_MAX, 1'b0);
        send_sample(Q_MAX, STEP_MAX, 1'b0);
        send_sample(Q_MIN, STEP_MAX, 1'b0);
        send_sample(Q_MIN, STEP_MAX, 1'b0);
        apply_config(Q_ONE, 32'sh8000, 32'sh4000, Q_MIN, Q_MAX, -32'sh1, -32'sh5);
        send_sample(32'sh1, STEP_W'(32'h400), 1'b0);
        apply_config(Q_ONE, 32'sh8000, 32'sh4000, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
        send_sample('0, STEP_W'(32'h10), 1'b0);
    endtask

    // Normal window, then an inverted one where the upper bound wins first.
    task automatic test_output_clamp();
        apply_config(Q_ONE, '0, '0, -Q_ONE, Q_ONE, '0, '0);
        send_sample(32'sh2_0000, STEP_W'(32'h400), 1'b0);
        send_sample(-32'sh2_0000, STEP_W'(32'h400), 1'b0);
        apply_config(Q_ONE, '0, '0, Q_ONE, -Q_ONE, '0, '0);
        send_sample(32'sh2_0000, STEP_W'(32'h400), 1'b0);
        send_sample(-32'sh2_0000, STEP_W'(32'h400), 1'b0);
        send_sample('0, STEP_W'(32'h400), 1'b0);
    endtask

    // Random phases, each with its own register set; early phases pin the gains.
    task automatic test_random_phases();
        logic signed [DW-1:0] gp, gi, gd, lo, hi, cap, db, w;
        for (int ph = 0; ph < 10; ph++) begin
            gp = pick_gain();
            gi = pick_gain();
            gd = pick_gain();
            if (ph == 0) begin
                gp = Q_MAX;
                gi = Q_MAX;
                gd = Q_MAX;
            end
            if (ph == 1) begin
                gp = Q_MIN;
                gi = Q_MIN;
                gd = Q_MIN;
            end
            case ($urandom_range(0, 4))
                0: begin
                    lo = Q_MIN;
                    hi = Q_MAX;
                end
                1: begin
                    lo = $urandom_range(0, 32'h8_0000);
                    hi = -$signed(32'($urandom_range(0, 32'h8_0000)));
                end
                default: begin
                    lo = -$signed(32'($urandom_range(0, 32'h8_0000)));
                    hi = $urandom_range(0, 32'h8_0000);
                end
            endcase
            case ($urandom_range(0, 4))
                0:       cap = '0;
                1:       cap = -$signed(32'($urandom_range(1, 32'h4_0000)));
                2:       cap = Q_MAX;
                default: cap = $urandom_range(1, 32'h4_0000);
            endcase
            case ($urandom_range(0, 7))
                0:       db = '0;
                1:       db = -$signed(32'($urandom_range(1, 32'h4000)));
                2:       db = Q_MIN;
                3:       db = (ph == 5) ? Q_MAX : 32'sh100;
                default: db = $urandom_range(0, 32'h4000);
            endcase
            apply_config(gp, gi, gd, lo, hi, cap, db);
            // Run a couple of phases with no idling on either side.
            steady_flow = (ph == 2 || ph == 3);
            for (int n = 0; n < 70; n++) begin
                w = pick_error();
                send_sample(w, pick_step(), $urandom_range(0, 29) == 0);
            end
        end
        steady_flow = 1'b0;
    endtask

    // Drive results: stall ready at random, compare each against the oldest prediction.
    initial
    begin : result_check
        int            stall;
        drive_result_t want;
        drive_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                drive_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            drive_ch.ready <= 1'b1;
            do @(posedge clk); while (!drive_ch.valid);
            if (expected_drives.size() == 0) begin
                $display("%0t unexpected drive result: got %0d skipped %0b", $time,
                         drive_ch.drive_out, drive_ch.skipped);
                faults++;
            end else begin
                want = expected_drives.pop_front();
                if (drive_ch.drive_out !== want.drive) begin
                    $display("%0t drive_out mismatch: expected %0d got %0d", $time,
                             want.drive, drive_ch.drive_out);
                    faults++;
                end
                if (drive_ch.skipped !== want.skipped) begin
                    $display("%0t skipped mismatch: expected %0b got %0b", $time,
                             want.skipped, drive_ch.skipped);
                    faults++;
                end
            end
        end
    end

    // Sequence: reset, directed checks, random phases, drain and report.
    initial
    begin
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.error_in    <= '0;
        sample_ch.time_step   <= '0;
        sample_ch.clear_state <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_extremes();
        test_dead_band();
        test_output_clamp();
        test_random_phases();
        settle_block();
        if (faults == 0)
            $display("[pid_deadzone_antiwindup] OK");
        else
            $display("[pid_deadzone_antiwindup] ERROR");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #20_000_000;
        $display("[pid_deadzone_antiwindup] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pda_pkg.sv
rtl/pda_sample_if.sv
rtl/pda_drive_if.sv
rtl/pda_cfg_if.sv
rtl/pda_mul.sv
rtl/pda_div.sv
rtl/pid_deadzone_antiwindup.sv
tb/pid_deadzone_antiwindup_tb.sv
